FILE: sv/ihrf_pkg.sv
// shared types and constants for the ipv4 header receive filter
package ihrf_pkg;

    localparam int WORD_W  = 16;
    localparam int IDX_W   = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [2:0] VERDICT_PASS      = 3'd0;
    localparam logic [2:0] VERDICT_CHECKSUM  = 3'd1;
    localparam logic [2:0] VERDICT_VERSION   = 3'd2;
    localparam logic [2:0] VERDICT_FOREIGN   = 3'd3;
    localparam logic [2:0] VERDICT_MALFORMED = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ADDR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BCAST_ADDR = 1'd1;

    localparam logic [31:0] LOCAL_ADDR_RESET = 32'h0102_0304;
    localparam logic [31:0] BCAST_ADDR_RESET = 32'hC0A8_78FF;

    localparam logic [7:0]       PROTO_UDP    = 8'd17;
    localparam logic [3:0]       IP_VERSION   = 4'd4;
    localparam logic [3:0]       MIN_IHL      = 4'd5;
    localparam logic [IDX_W-1:0] WORD_PROTO   = 5'd4;
    localparam logic [IDX_W-1:0] WORD_CSUM    = 5'd5;
    localparam logic [IDX_W-1:0] WORD_DST_HI  = 5'd8;
    localparam logic [IDX_W-1:0] WORD_DST_LO  = 5'd9;

    typedef struct packed {
        logic [2:0] verdict;
        logic [7:0] protocol_number;
        logic       deliver_udp;
    } t_result;

endpackage

FILE: sv/ihrf_if.sv
// channel interfaces: header word input, verdict output, register writes
interface ihrf_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] header_word;
    logic        first_word;
    modport source (output valid, header_word, first_word, input ready);
    modport sink   (input valid, header_word, first_word, output ready);
endinterface

interface ihrf_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] verdict;
    logic [7:0] protocol_number;
    logic       deliver_udp;
    modport source (output valid, verdict, protocol_number, deliver_udp, input ready);
    modport sink   (input valid, verdict, protocol_number, deliver_udp, output ready);
endinterface

interface ihrf_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  reg_index;
    logic [31:0] data;
    modport source (output valid, reg_index, data, input ready);
    modport sink   (input valid, reg_index, data, output ready);
endinterface

FILE: sv/ipv4_header_receive_filter.sv
// top level of the ipv4 header receive filter
//
// i_in carries 16-bit big-endian header words; first_word marks word 0 of a
// new header. Header length is IHL*2 words. A ones' complement sum runs over
// the header with the checksum word counted as zero, and version, protocol,
// checksum and destination are captured on the way.
// After the last header word one item goes out on o_out: verdict, protocol
// and a deliver-to-udp flag. A header with IHL below 5 gives a malformed
// verdict right on its first word. Words outside a header give nothing.
// i_cfg writes the local address (index 0) and broadcast address (index 1);
// it is always ready.
// Throughput is one word per cycle while input ready is high. The verdict
// of the last header word goes into the output register, or into the skid
// register while the output stalls; sum, capture and compare are combinational.
// A skid register behind the output register lets input continue while a
// verdict waits; input ready drops only when both hold an item.
// Reset (i_rst_n low, synchronous) empties both registers, puts the
// addresses to their defaults and leaves the block idle until a first word.
module ipv4_header_receive_filter
    import ihrf_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    ihrf_in_if.sink       i_in,
    ihrf_out_if.source    o_out,
    ihrf_cfg_if.sink      i_cfg
);

    logic [31:0]       r_local_addr;
    logic [31:0]       r_bcast_addr;
    logic [IDX_W-1:0]  r_idx,     n_idx;
    logic [IDX_W-1:0]  r_hw,      n_hw;
    logic [WORD_W-1:0] r_sum,     n_sum;
    logic [3:0]        r_version, n_version;
    logic [7:0]        r_prot,    n_prot;
    logic [WORD_W-1:0] r_csum,    n_csum;
    logic [31:0]       r_dst,     n_dst;
    logic              r_done,    n_done;
    logic              r_out_valid,  n_out_valid;
    logic              r_skid_valid, n_skid_valid;
    t_result           r_out,  n_out;
    t_result           r_skid, n_skid;

    logic              in_fire;
    logic              out_take;
    logic              res_valid;
    t_result           res;
    logic [WORD_W-1:0] w;
    logic [3:0]        ihl;
    logic [WORD_W:0]   raw_sum;
    logic [WORD_W-1:0] add_sum;
    logic              last;
    logic [2:0]        verdict;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_skid_valid;
    assign in_fire     = i_in.valid && i_in.ready;
    assign out_take    = o_out.valid && o_out.ready;

    assign o_out.valid           = r_out_valid;
    assign o_out.verdict         = r_out.verdict;
    assign o_out.protocol_number = r_out.protocol_number;
    assign o_out.deliver_udp     = r_out.deliver_udp;

    assign w   = i_in.header_word;
    assign ihl = w[11:8];

    // header processing
    always_comb begin
        n_idx     = r_idx;
        n_hw      = r_hw;
        n_sum     = r_sum;
        n_version = r_version;
        n_prot    = r_prot;
        n_csum    = r_csum;
        n_dst     = r_dst;
        n_done    = r_done;
        res_valid = 1'b0;
        res       = '0;
        raw_sum   = '0;
        add_sum   = '0;
        last      = 1'b0;
        verdict   = VERDICT_PASS;
        if (in_fire && (i_in.first_word || !r_done)) begin
            if (i_in.first_word) begin
                n_idx     = '0;
                n_sum     = '0;
                n_version = w[15:12];
                n_prot    = '0;
                n_csum    = '0;
                n_dst     = '0;
                n_hw      = {ihl, 1'b0};
                n_done    = 1'b0;
            end
            if (i_in.first_word && (ihl < MIN_IHL)) begin
                n_done    = 1'b1;
                res_valid = 1'b1;
                res.verdict = VERDICT_MALFORMED;
            end else begin
                if (n_idx == WORD_PROTO)  n_prot = w[7:0];
                if (n_idx == WORD_CSUM)   n_csum = w;
                if (n_idx == WORD_DST_HI) n_dst  = {w, n_dst[15:0]};
                if (n_idx == WORD_DST_LO) n_dst  = {n_dst[31:16], w};
                raw_sum = {1'b0, n_sum} + {1'b0, w};
                add_sum = raw_sum[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, raw_sum[WORD_W]};
                if (n_idx != WORD_CSUM) n_sum = add_sum;
                last = ({1'b0, n_idx} + 6'd1) >= {1'b0, n_hw};
                if (!last) begin
                    n_idx = n_idx + 5'd1;
                end else begin
                    n_done = 1'b1;
                    priority if (~n_sum != n_csum)
                        verdict = VERDICT_CHECKSUM;
                    else if (n_version != IP_VERSION)
                        verdict = VERDICT_VERSION;
                    else if ((n_dst == r_local_addr) || (n_dst == r_bcast_addr))
                        verdict = VERDICT_PASS;
                    else
                        verdict = VERDICT_FOREIGN;
                    res_valid           = 1'b1;
                    res.verdict         = verdict;
                    res.protocol_number = n_prot;
                    res.deliver_udp     = (verdict == VERDICT_PASS) && (n_prot == PROTO_UDP);
                end
            end
        end
    end

    // output register and skid
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out        = res;
                n_out_valid  = res_valid;
            end
        end else if (res_valid) begin
            n_skid       = res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_addr <= LOCAL_ADDR_RESET;
            r_bcast_addr <= BCAST_ADDR_RESET;
            r_idx        <= '0;
            r_hw         <= '0;
            r_sum        <= '0;
            r_version    <= '0;
            r_prot       <= '0;
            r_csum       <= '0;
            r_dst        <= '0;
            r_done       <= 1'b1;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.reg_index)
                    REG_LOCAL_ADDR: r_local_addr <= i_cfg.data;
                    REG_BCAST_ADDR: r_bcast_addr <= i_cfg.data;
                    default: ;
                endcase
            end
            r_idx        <= n_idx;
            r_hw         <= n_hw;
            r_sum        <= n_sum;
            r_version    <= n_version;
            r_prot       <= n_prot;
            r_csum       <= n_csum;
            r_dst        <= n_dst;
            r_done       <= n_done;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

FILE: bench/ihrf_verdict_checker.sv
`timescale 1ns / 100ps
// verdict checker: follows the header word stream, predicts each verdict and compares
module ihrf_verdict_checker
    import ihrf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    ihrf_in_if   i_in_mon,
    ihrf_out_if  i_out_mon,
    ihrf_cfg_if  i_cfg_mon,
    output int   o_fail_count,
    output int   o_pending
);

    t_result     verdicts_due [$];
    t_result     got;
    t_result     want;
    logic [31:0] local_addr;
    logic [31:0] bcast_addr;
    logic [31:0] dst_seen;
    logic [15:0] sum_acc;
    logic [15:0] csum_seen;
    logic [15:0] csum_calc;
    logic [15:0] w;
    logic [16:0] sum_wide;
    logic [4:0]  word_idx;
    logic [4:0]  hdr_len;
    logic [3:0]  ver_seen;
    logic [7:0]  proto_seen;
    logic [2:0]  v;
    logic        hdr_idle;
    logic        in_header;
    int          errors = 0;

    assign o_fail_count = errors;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            verdicts_due.delete();
            local_addr = LOCAL_ADDR_RESET;
            bcast_addr = BCAST_ADDR_RESET;
            word_idx   = '0;
            sum_acc    = '0;
            hdr_len    = '0;
            ver_seen   = '0;
            proto_seen = '0;
            csum_seen  = '0;
            dst_seen   = '0;
            hdr_idle   = 1'b1;
        end else begin
            if (i_cfg_mon.valid && i_cfg_mon.ready) begin
                if (i_cfg_mon.reg_index == REG_LOCAL_ADDR) begin
                    local_addr = i_cfg_mon.data;
                end else begin
                    bcast_addr = i_cfg_mon.data;
                end
            end

            if (i_out_mon.valid && i_out_mon.ready) begin
                got = '{i_out_mon.verdict, i_out_mon.protocol_number, i_out_mon.deliver_udp};
                if (verdicts_due.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("%0t: verdict item with none due: %0d/%0d/%0d", $time,
                                 got.verdict, got.protocol_number, got.deliver_udp);
                    end
                end else begin
                    want = verdicts_due.pop_front();
                    if (got.verdict !== want.verdict
                            || got.protocol_number !== want.protocol_number
                            || got.deliver_udp !== want.deliver_udp) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("%0t: verdict/protocol/udp expected %0d/%0d/%0d got %0d/%0d/%0d",
                                     $time, want.verdict, want.protocol_number,
                                     want.deliver_udp, got.verdict, got.protocol_number,
                                     got.deliver_udp);
                        end
                    end
                end
            end

            if (i_in_mon.valid && i_in_mon.ready) begin
                w = i_in_mon.header_word;
                in_header = 1'b1;
                if (i_in_mon.first_word) begin
                    word_idx   = '0;
                    sum_acc    = '0;
                    ver_seen   = w[15:12];
                    proto_seen = '0;
                    csum_seen  = '0;
                    dst_seen   = '0;
                    hdr_len    = {w[11:8], 1'b0};
                    if (w[11:8] < MIN_IHL) begin
                        hdr_idle = 1'b1;
                        in_header = 1'b0;
                        verdicts_due.push_back('{VERDICT_MALFORMED, 8'd0, 1'b0});
                    end else begin
                        hdr_idle = 1'b0;
                    end
                end else if (hdr_idle) begin
                    in_header = 1'b0;
                end

                if (in_header) begin
                    case (word_idx)
                        WORD_PROTO:  proto_seen = w[7:0];
                        WORD_CSUM:   csum_seen = w;
                        WORD_DST_HI: dst_seen[31:16] = w;
                        WORD_DST_LO: dst_seen[15:0] = w;
                        default: ;
                    endcase
                    if (word_idx != WORD_CSUM) begin
                        sum_wide = {1'b0, sum_acc} + {1'b0, w};
                        sum_acc  = sum_wide[15:0] + {15'd0, sum_wide[16]};
                    end

                    if (({1'b0, word_idx} + 6'd1) < {1'b0, hdr_len}) begin
                        word_idx = word_idx + 5'd1;
                    end else begin
                        hdr_idle  = 1'b1;
                        csum_calc = ~sum_acc;
                        if (csum_calc != csum_seen) begin
                            v = VERDICT_CHECKSUM;
                        end else if (ver_seen != IP_VERSION) begin
                            v = VERDICT_VERSION;
                        end else if (dst_seen == local_addr || dst_seen == bcast_addr) begin
                            v = VERDICT_PASS;
                        end else begin
                            v = VERDICT_FOREIGN;
                        end
                        verdicts_due.push_back('{v, proto_seen,
                                                 (v == VERDICT_PASS) && (proto_seen == PROTO_UDP)});
                    end
                end
            end
        end
        o_pending <= verdicts_due.size();
    end

endmodule

FILE: bench/tb_ipv4_header_receive_filter.sv
`timescale 1ns / 100ps
// testbench top: drives header words, address writes and output stalls, gives the verdict
module tb_ipv4_header_receive_filter;
    import ihrf_pkg::*;

    typedef enum int {CS_GOOD, CS_BAD, CS_ZERO, CS_NEG_ZERO} t_csum_kind;

    localparam int WORDS_PER_PHASE = 330;
    localparam int IDLE_PCT        = 31;
    localparam int NUM_PHASES      = 5;

    logic        i_clk;
    logic        i_rst_n;
    bit          steady_run = 1'b0;
    int          fail_count;
    int          pending_count;
    int          words_sent;
    logic [31:0] local_cur;
    logic [31:0] bcast_cur;

    ihrf_in_if  in_ch ();
    ihrf_out_if out_ch ();
    ihrf_cfg_if cfg_ch ();

    ipv4_header_receive_filter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    ihrf_verdict_checker verdict_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_cfg_mon    (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("ipv4_header_receive_filter: mismatch");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic send_word(input logic [15:0] w, input logic f);
        while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.header_word <= w;
        in_ch.first_word  <= f;
        do @(posedge i_clk); while (!in_ch.ready);
        words_sent++;
    endtask

    // keep == 0 or keep above the header length sends the whole header, otherwise only its first keep words
    task automatic send_header(input logic [3:0] ver, input logic [3:0] ihl,
                               input logic [7:0] proto, input logic [31:0] dst,
                               input t_csum_kind kind, input int keep);
        logic [15:0] hdr [30];
        logic [16:0] acc;
        logic [15:0] sum;
        int          n;
        int          i;
        n = 2 * ihl;
        for (i = 0; i < n; i++) begin
            hdr[i] = 16'($urandom);
        end
        hdr[0]      = {ver, ihl, hdr[0][7:0]};
        hdr[4][7:0] = proto;
        hdr[5]      = '0;
        hdr[8]      = dst[31:16];
        hdr[9]      = dst[15:0];
        if (kind == CS_ZERO || kind == CS_NEG_ZERO) begin
            hdr[3] = '0;
        end
        acc = '0;
        for (i = 0; i < n; i++) begin
            acc = {1'b0, acc[15:0]} + {1'b0, hdr[i]};
            acc = acc[15:0] + {16'd0, acc[16]};
        end
        sum = acc[15:0];
        // force the sum to all ones so the computed checksum is zero
        if (kind == CS_ZERO || kind == CS_NEG_ZERO) begin
            hdr[3] = ~sum;
            sum    = 16'hFFFF;
        end
        case (kind)
            CS_BAD:      hdr[5] = ~sum ^ 16'($urandom_range(1, 65535));
            CS_NEG_ZERO: hdr[5] = 16'hFFFF;
            default:     hdr[5] = ~sum;
        endcase
        if (keep == 0 || keep > n) begin
            keep = n;
        end
        for (i = 0; i < keep; i++) begin
            send_word(hdr[i], i == 0);
        end
    endtask

    task automatic wait_settled();
        in_ch.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_addresses(input logic [31:0] loc, input logic [31:0] bc);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= REG_LOCAL_ADDR;
        cfg_ch.data      <= loc;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.reg_index <= REG_BCAST_ADDR;
        cfg_ch.data      <= bc;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        local_cur = loc;
        bcast_cur = bc;
    endtask

    initial begin
        logic [31:0] loc_set [NUM_PHASES];
        logic [31:0] bc_set [NUM_PHASES];
        logic [31:0] dst;
        logic [3:0]  ihl;
        logic [3:0]  ver;
        logic [7:0]  proto;
        t_csum_kind  kind;
        int          pick;
        int          sel;
        int          phase;

        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.header_word = '0;
        in_ch.first_word  = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.reg_index  = REG_LOCAL_ADDR;
        cfg_ch.data       = '0;
        local_cur         = LOCAL_ADDR_RESET;
        bcast_cur         = BCAST_ADDR_RESET;

        loc_set[1] = 32'h0000_0000;
        bc_set[1]  = 32'hFFFF_FFFF;
        loc_set[2] = 32'hFFFF_FFFF;
        bc_set[2]  = 32'h0000_0000;
        loc_set[3] = $urandom;
        bc_set[3]  = $urandom;
        loc_set[4] = $urandom;
        bc_set[4]  = loc_set[4];

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed headers under the reset addresses
        send_header(IP_VERSION, MIN_IHL, PROTO_UDP, local_cur, CS_GOOD, 0);
        send_header(IP_VERSION, MIN_IHL, 8'd6, bcast_cur, CS_GOOD, 0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0000, 1'b0);
        send_header(IP_VERSION, MIN_IHL, PROTO_UDP, local_cur, CS_BAD, 0);
        send_header(4'd6, MIN_IHL, PROTO_UDP, local_cur, CS_GOOD, 0);
        send_header(IP_VERSION, MIN_IHL, PROTO_UDP, 32'h0A00_0001, CS_GOOD, 0);
        send_header(IP_VERSION, MIN_IHL, PROTO_UDP, local_cur, CS_ZERO, 0);
        send_header(IP_VERSION, MIN_IHL, PROTO_UDP, local_cur, CS_NEG_ZERO, 0);
        send_word(16'h4000, 1'b1);
        send_word(16'hF4FF, 1'b1);
        send_header(IP_VERSION, 4'd15, 8'hFF, bcast_cur, CS_GOOD, 0);
        send_header(4'd15, 4'd15, 8'h00, local_cur, CS_GOOD, 0);
        send_header(4'd0, MIN_IHL, 8'h00, local_cur, CS_GOOD, 0);
        send_header(IP_VERSION, 4'd6, PROTO_UDP, local_cur, CS_GOOD, 4);
        send_header(IP_VERSION, 4'd6, PROTO_UDP, local_cur, CS_GOOD, 0);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                wait_settled();
                set_addresses(loc_set[phase], bc_set[phase]);
            end
            steady_run <= (phase == 2);
            words_sent = 0;
            while (words_sent < WORDS_PER_PHASE) begin
                pick = $urandom_range(99);
                ihl  = ($urandom_range(99) < 70) ? MIN_IHL : 4'($urandom_range(6, 15));
                if (pick < 72) begin
                    ver = ($urandom_range(99) < 90) ? IP_VERSION : 4'($urandom);
                    sel = $urandom_range(99);
                    if (sel < 35) begin
                        dst = local_cur;
                    end else if (sel < 60) begin
                        dst = bcast_cur;
                    end else if (sel < 80) begin
                        dst = local_cur ^ (32'd1 << $urandom_range(31));
                    end else begin
                        dst = $urandom;
                    end
                    proto = ($urandom_range(99) < 50) ? PROTO_UDP : 8'($urandom);
                    sel   = $urandom_range(99);
                    kind  = (sel < 82) ? CS_GOOD : (sel < 88) ? CS_ZERO :
                            (sel < 92) ? CS_NEG_ZERO : CS_BAD;
                    send_header(ver, ihl, proto, dst, kind, 0);
                    // words past the header end are ignored
                    repeat ($urandom_range(0, 1)) send_word(16'($urandom), 1'b0);
                end else if (pick < 80) begin
                    send_word({4'($urandom), 4'($urandom_range(0, 4)), 8'($urandom)}, 1'b1);
                end else if (pick < 90) begin
                    send_header(IP_VERSION, ihl, PROTO_UDP, local_cur, CS_GOOD,
                                $urandom_range(1, 2 * ihl - 1));
                end else begin
                    send_word(16'($urandom), 1'b0);
                end
            end
        end

        wait_settled();
        if (fail_count == 0) begin
            $display("ipv4_header_receive_filter: match");
        end else begin
            $display("ipv4_header_receive_filter: mismatch");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/ihrf_pkg.sv
sv/ihrf_if.sv
sv/ipv4_header_receive_filter.sv
bench/ihrf_verdict_checker.sv
bench/tb_ipv4_header_receive_filter.sv
